[hw/rtl/l1pc_pkg.sv]
// l1pc_pkg: shared types, codes and constants of the L1-post cell count block
// no dependencies; imported by every other file of the block

package l1pc_pkg;

    // queue depth between the front and the back
    localparam int unsigned L1PC_QUEUE_DEPTH = 4;

    // l1 modulation codes
    localparam logic [3:0] L1_MOD_BPSK  = 4'd0;
    localparam logic [3:0] L1_MOD_QPSK  = 4'd1;
    localparam logic [3:0] L1_MOD_16QAM = 4'd2;
    localparam logic [3:0] L1_MOD_64QAM = 4'd3;

    // fft mode codes
    localparam logic [2:0] FFT_2K    = 3'd0;
    localparam logic [2:0] FFT_8K    = 3'd1;
    localparam logic [2:0] FFT_4K    = 3'd2;
    localparam logic [2:0] FFT_1K    = 3'd3;
    localparam logic [2:0] FFT_16K   = 3'd4;
    localparam logic [2:0] FFT_32K   = 3'd5;
    localparam logic [2:0] FFT_8K_E  = 3'd6;
    localparam logic [2:0] FFT_32K_E = 3'd7;

    // coding constants
    localparam logic [12:0] L1PC_KBCH        = 13'd7032;
    localparam logic [5:0]  L1PC_CRC_M1      = 6'd31;     // crc length minus one
    localparam logic [13:0] L1PC_PARITY_BITS = 14'd9168;  // bch 168 plus ldpc 9000
    localparam logic [5:0]  L1PC_MAX_BLOCKS  = 6'd38;

    // reciprocals for division by small constants, scaled by 2^20, 2^18, 2^16
    localparam logic [7:0]  L1PC_KBCH_RECIP = 8'd149;
    localparam logic [15:0] L1PC_RECIP5     = 16'd52428;
    localparam logic [14:0] L1PC_RECIP3     = 15'd21845;

    // one classified word as it leaves the front
    typedef struct packed {
        logic [18:0] x1;          // info bits plus crc minus one
        logic [6:0]  mult_m1;     // rounding multiple minus one
        logic [2:0]  ceil_shift;  // log2 of the power-of-two part of the multiple
        logic        div3;        // 64qam: multiple holds a factor of three
        logic [2:0]  p2_shift;    // log2 of the effective p2 symbol count
    } t_l1pc_job;

    // floor(2^20 / b) for block counts 1..38
    function automatic logic [20:0] l1pc_blk_recip(input logic [5:0] b);
        logic [20:0] r;
        case (b)
            6'd1:    r = 21'd1048576;
            6'd2:    r = 21'd524288;
            6'd3:    r = 21'd349525;
            6'd4:    r = 21'd262144;
            6'd5:    r = 21'd209715;
            6'd6:    r = 21'd174762;
            6'd7:    r = 21'd149796;
            6'd8:    r = 21'd131072;
            6'd9:    r = 21'd116508;
            6'd10:   r = 21'd104857;
            6'd11:   r = 21'd95325;
            6'd12:   r = 21'd87381;
            6'd13:   r = 21'd80659;
            6'd14:   r = 21'd74898;
            6'd15:   r = 21'd69905;
            6'd16:   r = 21'd65536;
            6'd17:   r = 21'd61680;
            6'd18:   r = 21'd58254;
            6'd19:   r = 21'd55188;
            6'd20:   r = 21'd52428;
            6'd21:   r = 21'd49932;
            6'd22:   r = 21'd47662;
            6'd23:   r = 21'd45590;
            6'd24:   r = 21'd43690;
            6'd25:   r = 21'd41943;
            6'd26:   r = 21'd40329;
            6'd27:   r = 21'd38836;
            6'd28:   r = 21'd37449;
            6'd29:   r = 21'd36157;
            6'd30:   r = 21'd34952;
            6'd31:   r = 21'd33825;
            6'd32:   r = 21'd32768;
            6'd33:   r = 21'd31775;
            6'd34:   r = 21'd30840;
            6'd35:   r = 21'd29959;
            6'd36:   r = 21'd29127;
            6'd37:   r = 21'd28339;
            6'd38:   r = 21'd27594;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/l1pc_if.sv]
// l1pc_if: valid/ready channel interfaces of the L1-post cell count block
// depends on l1pc_pkg for the classified word type

interface l1pc_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  l1_mod_code;
    logic [2:0]  fft_mode_code;
    logic [17:0] post_info_bits;

    modport source (output valid, output l1_mod_code, output fft_mode_code,
                    output post_info_bits, input ready);
    modport sink   (input valid, input l1_mod_code, input fft_mode_code,
                    input post_info_bits, output ready);
endinterface

interface l1pc_rsp_if;
    logic        valid;
    logic        ready;
    logic [19:0] total_cells;
    logic [5:0]  fec_block_count;

    modport source (output valid, output total_cells, output fec_block_count, input ready);
    modport sink   (input valid, input total_cells, input fec_block_count, output ready);
endinterface

interface l1pc_job_if import l1pc_pkg::*; ;
    logic      valid;
    logic      ready;
    t_l1pc_job job;

    modport source (output valid, output job, input ready);
    modport sink   (input valid, input job, output ready);
endinterface

[hw/rtl/l1pc_front.sv]
// l1pc_front: accepts request words, decodes modulation and fft mode codes
// depends on l1pc_pkg and l1pc_if

module l1pc_front import l1pc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    l1pc_req_if.sink   i_req,
    l1pc_job_if.source o_job
);

    logic      r_vld;
    t_l1pc_job r_job;
    t_l1pc_job n_job;
    logic [2:0] w_eta;
    logic [2:0] w_eta_shift;

    assign i_req.ready = !r_vld || o_job.ready;
    assign o_job.valid = r_vld;
    assign o_job.job   = r_job;

    always_comb begin
        n_job = '0;
        case (i_req.l1_mod_code)
            L1_MOD_QPSK: begin
                w_eta = 3'd2; w_eta_shift = 3'd1; n_job.div3 = 1'b0;
            end
            L1_MOD_16QAM: begin
                w_eta = 3'd4; w_eta_shift = 3'd2; n_job.div3 = 1'b0;
            end
            L1_MOD_64QAM: begin
                // 6 = 2 * 3: power-of-two part by shift, the three in the back
                w_eta = 3'd6; w_eta_shift = 3'd1; n_job.div3 = 1'b1;
            end
            default: begin
                w_eta = 3'd1; w_eta_shift = 3'd0; n_job.div3 = 1'b0;
            end
        endcase
        case (i_req.fft_mode_code)
            FFT_1K:           n_job.p2_shift = 3'd4;
            FFT_2K:           n_job.p2_shift = 3'd3;
            FFT_4K:           n_job.p2_shift = 3'd2;
            FFT_8K, FFT_8K_E: n_job.p2_shift = 3'd1;
            // one p2 symbol rounds as two
            default:          n_job.p2_shift = 3'd1;
        endcase
        n_job.mult_m1    = (7'(w_eta) << n_job.p2_shift) - 7'd1;
        n_job.ceil_shift = n_job.p2_shift + w_eta_shift;
        n_job.x1         = 19'(i_req.post_info_bits) + 19'(L1PC_CRC_M1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_job <= n_job;
        end
    end

endmodule

[hw/rtl/l1pc_queue.sv]
// l1pc_queue: small fifo of classified words between front and back
// depends on l1pc_pkg and l1pc_if

module l1pc_queue import l1pc_pkg::*; #(
    parameter int unsigned DEPTH = L1PC_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    l1pc_job_if.sink   i_job,
    l1pc_job_if.source o_job
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_l1pc_job       r_mem [DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wptr;
    logic [PW-1:0]   n_rptr;
    logic [CW-1:0]   n_cnt;
    logic            w_push;
    logic            w_pop;

    assign i_job.ready = (r_cnt != CW'(DEPTH));
    assign o_job.valid = (r_cnt != '0);
    assign o_job.job   = r_mem[r_rptr];
    assign w_push      = i_job.valid && i_job.ready;
    assign w_pop       = o_job.valid && o_job.ready;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job.job;
        end
    end

endmodule

[hw/rtl/l1pc_back.sv]
// l1pc_back: ten-stage arithmetic pipeline from classified word to cell count
// depends on l1pc_pkg and l1pc_if

module l1pc_back import l1pc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    l1pc_job_if.sink   i_job,
    l1pc_rsp_if.source o_rsp
);

    localparam int unsigned NSTG = 10;
    localparam logic [2:0] PUNC_NUM = 3'd6;
    localparam logic [2:0] PUNC_DEN = 3'd5;
    localparam logic [1:0] DIV3_DEN = 2'd3;

    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    // classified word travels along stages 1..9
    t_l1pc_job   r_job [NSTG-1];
    // block count travels along stages 2..9
    logic [5:0]  r_blk [NSTG-2];

    logic [5:0]  r_s1_bq0;
    logic [18:0] r_s3_x2;
    logic [12:0] r_s3_kq0;
    logic [12:0] r_s4_ksig;
    logic [12:0] r_s5_ksig;
    logic [15:0] r_s5_y;
    logic [13:0] r_s5_pq0;
    logic [14:0] r_s6_tmp;
    logic [12:0] r_s7_d;
    logic [12:0] r_s8_d;
    logic [12:0] r_s8_e;
    logic [11:0] r_s8_q0;
    logic [12:0] r_s9_q;
    logic [19:0] r_out_total;
    logic [5:0]  r_out_blk;

    logic [5:0]  n_s1_bq0;
    logic [5:0]  n_s2_blk;
    logic [18:0] n_s3_x2;
    logic [12:0] n_s3_kq0;
    logic [12:0] n_s4_ksig;
    logic [15:0] n_s5_y;
    logic [13:0] n_s5_pq0;
    logic [14:0] n_s6_tmp;
    logic [12:0] n_s7_d;
    logic [12:0] n_s8_e;
    logic [11:0] n_s8_q0;
    logic [12:0] n_s9_q;
    logic [19:0] n_out_total;

    logic [26:0] w_prod1;
    logic [18:0] w_brem;
    logic [39:0] w_prod2;
    logic [18:0] w_krem;
    logic [31:0] w_prod5;
    logic [15:0] w_prem;
    logic [13:0] w_punc0;
    logic [13:0] w_punc;
    logic [15:0] w_tmp;
    logic [15:0] w_round;
    logic [15:0] w_dfull;
    logic [27:0] w_prod8;
    logic [12:0] w_qrem;
    logic [11:0] w_q3;
    logic [18:0] w_qb;
    logic [23:0] w_total;

    // whole pipeline moves together whenever the output register frees up
    assign w_adv = !r_vld[NSTG-1] || o_rsp.ready;

    assign i_job.ready           = w_adv;
    assign o_rsp.valid           = r_vld[NSTG-1];
    assign o_rsp.total_cells     = r_out_total;
    assign o_rsp.fec_block_count = r_out_blk;

    always_comb begin
        // s1: estimate of floor(x1 / 7032), low by at most one
        w_prod1  = 27'(i_job.job.x1) * 27'(L1PC_KBCH_RECIP);
        n_s1_bq0 = w_prod1[25:20];

        // s2: correct the estimate, blocks = floor((k-1)/7032) + 1
        w_brem   = r_job[0].x1 - 19'(r_s1_bq0) * 19'(L1PC_KBCH);
        n_s2_blk = r_s1_bq0 + 6'(w_brem >= 19'(L1PC_KBCH)) + 6'd1;

        // s3: ksig = floor((k + blocks - 1) / blocks) by reciprocal table
        n_s3_x2  = r_job[1].x1 + 19'(r_blk[0]);
        w_prod2  = 40'(n_s3_x2) * 40'(l1pc_blk_recip(r_blk[0]));
        n_s3_kq0 = w_prod2[32:20];

        // s4: correct ksig
        w_krem    = r_s3_x2 - 19'(r_s3_kq0) * 19'(r_blk[1]);
        n_s4_ksig = r_s3_kq0 + 13'(w_krem >= 19'(r_blk[1]));

        // s5: puncturing numerator and estimate of its fifth
        n_s5_y   = 16'(PUNC_NUM) * (16'(L1PC_KBCH) - 16'(r_s4_ksig));
        w_prod5  = 32'(n_s5_y) * 32'(L1PC_RECIP5);
        n_s5_pq0 = w_prod5[31:18];

        // s6: correct, clamp to multiple minus one, then remaining bits
        w_prem   = r_s5_y - 16'(r_s5_pq0) * 16'(PUNC_DEN);
        w_punc0  = r_s5_pq0 + 14'(w_prem >= 16'(PUNC_DEN));
        w_punc   = (w_punc0 < 14'(r_job[4].mult_m1)) ? 14'(r_job[4].mult_m1) : w_punc0;
        w_tmp    = 16'(r_s5_ksig) + 16'(L1PC_PARITY_BITS) - 16'(w_punc);
        n_s6_tmp = w_tmp[14:0];

        // s7: ceiling by the power-of-two part of the multiple
        w_round = (16'd1 << r_job[5].ceil_shift) - 16'd1;
        w_dfull = (16'(r_s6_tmp) + w_round) >> r_job[5].ceil_shift;
        n_s7_d  = w_dfull[12:0];

        // s8: ceil(d / 3) = floor((d + 2) / 3), estimate
        n_s8_e  = r_s7_d + 13'd2;
        w_prod8 = 28'(n_s8_e) * 28'(L1PC_RECIP3);
        n_s8_q0 = w_prod8[27:16];

        // s9: correct the third, used only for 64qam
        w_qrem = r_s8_e - 13'(r_s8_q0) * 13'(DIV3_DEN);
        w_q3   = r_s8_q0 + 12'(w_qrem >= 13'(DIV3_DEN));
        n_s9_q = r_job[7].div3 ? 13'(w_q3) : r_s8_d;

        // out: cells = q * p2 * blocks
        w_qb        = 19'(r_s9_q) * 19'(r_blk[7]);
        w_total     = 24'(w_qb) << r_job[8].p2_shift;
        n_out_total = w_total[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_job.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_job[0] <= i_job.job;
            for (int i = 1; i < NSTG - 1; i++) begin
                r_job[i] <= r_job[i-1];
            end
            r_blk[0] <= n_s2_blk;
            for (int i = 1; i < NSTG - 2; i++) begin
                r_blk[i] <= r_blk[i-1];
            end
            r_s1_bq0    <= n_s1_bq0;
            r_s3_x2     <= n_s3_x2;
            r_s3_kq0    <= n_s3_kq0;
            r_s4_ksig   <= n_s4_ksig;
            r_s5_ksig   <= r_s4_ksig;
            r_s5_y      <= n_s5_y;
            r_s5_pq0    <= n_s5_pq0;
            r_s6_tmp    <= n_s6_tmp;
            r_s7_d      <= n_s7_d;
            r_s8_d      <= r_s7_d;
            r_s8_e      <= n_s8_e;
            r_s8_q0     <= n_s8_q0;
            r_s9_q      <= n_s9_q;
            r_out_total <= n_out_total;
            r_out_blk   <= r_blk[7];
        end
    end

endmodule

[hw/rtl/l1_post_cell_count_core.sv]
// l1_post_cell_count_core: top level of the L1-post cell count block
// depends on l1pc_pkg, l1pc_if, l1pc_front, l1pc_queue and l1pc_back
//
// usage
//   i_req carries one request word: l1_mod_code, fft_mode_code and
//   post_info_bits; o_rsp returns one word per request, in order:
//   total_cells and fec_block_count. both channels use valid/ready, a
//   word moves on a rising edge with valid and ready high.
//   throughput: one word per cycle, sustained while o_rsp does not stall.
//   path: with no stall, the accept edge loads the front register; from
//   there the word moves into the queue and then through the back
//   pipeline to its output register.
//   when o_rsp stalls the back pipeline holds as a whole; the front keeps
//   taking words until the queue (QUEUE_DEPTH words) and the front
//   register are full, then i_req.ready drops.
//   reset (synchronous, active low) empties front, queue and pipeline;
//   i_req.ready is high in the first cycle after reset.

module l1_post_cell_count_core import l1pc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = L1PC_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    l1pc_req_if.sink   i_req,
    l1pc_rsp_if.source o_rsp
);

    l1pc_job_if u_front_q ();
    l1pc_job_if u_q_back ();

    l1pc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_job   (u_front_q.source)
    );

    l1pc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (u_front_q.sink),
        .o_job   (u_q_back.source)
    );

    l1pc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (u_q_back.sink),
        .o_rsp   (o_rsp)
    );

`ifndef ASSERT_OFF
    a_blk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.fec_block_count >= 6'd1) &&
                        (o_rsp.fec_block_count <= L1PC_MAX_BLOCKS))
        else $error("fec block count out of range");

    a_total_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.total_cells != '0))
        else $error("zero cell count on a valid response");

    a_rst_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_rsp.valid && i_req.ready && !u_q_back.valid)
        else $error("pipeline not empty after reset");
`endif

endmodule
